>>> rtl/core/lpol_pkg.sv
// shared widths, constants and status type of the position outer loop
`default_nettype none

package lpol_pkg;

    // gains, leak, slew rate and time step are all 16 bit operands
    localparam int OPND_W = 16;
    localparam int NUDGE_W = 16;
    localparam int LIMIT_W = 15;
    localparam int CFG_IDX_W = 3;

    // serial multiplier steps through one operand bit a cycle
    localparam int MUL_CNT_W = 4;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(OPND_W - 1);

    // microseconds per second, divisor of the serial divider
    localparam int DEN_W = 20;
    localparam logic [DEN_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [DEN_W-1:0] US_HALF = 20'd500000;

    // status of a shared serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/leaky_position_outer_loop.sv
// position outer loop: leaky drift integrator, pd nudge, clamp and slew limit
//
// channel  dir  payload (low bit up)                       handshake
// s_       in   tdata: wheel_speed, step_us; tuser: op     s_tvalid / s_tready
// m_       out  tdata: lean_nudge; tuser: held             m_tvalid / m_tready
// cfg_     in   cfg_index, cfg_data                        cfg_valid / cfg_ready
//
// an update runs five products on one serial multiplier and two divisions
// by one million on one serial divider
// restart and zero-step requests use neither serial unit
// one request is worked at a time; s_tready is high only when idle
// a finished result waits in the output register; a new request is taken
// meanwhile, and its result waits until the register is free
// aresetn (synchronous) clears state, integrator, last nudge and output valid,
// and loads the configuration registers with their reset values
`default_nettype none

module leaky_position_outer_loop
    import lpol_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = 32,
    parameter int SPEED_WIDTH      = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // request channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // tdata: wheel_speed, step_us, zero padding
    input  wire logic [((SPEED_WIDTH+OPND_W+7)/8)*8-1:0] s_tdata,
    // tuser: op
    input  wire logic [0:0]             s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // tdata: lean_nudge
    output logic [NUDGE_W-1:0]          m_tdata,
    // tuser: held
    output logic [0:0]                  m_tuser,
    // register writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [OPND_W-1:0]      cfg_data
);

    localparam int IW        = INTEGRATOR_WIDTH;
    localparam int SW        = SPEED_WIDTH;
    localparam int PR_W      = IW + OPND_W;
    localparam int P_W       = SW + OPND_W - 1;
    localparam int INC_SHIFT = 12;
    localparam int DIV_W     = P_W + INC_SHIFT + 1;
    localparam int INC_W     = SW + 8;
    localparam int SUM_W     = ((IW > INC_W + 1) ? IW : INC_W + 1) + 1;
    localparam int LEAK_SHIFT = 16;
    localparam int POS_SHIFT = 24;
    localparam int VEL_SHIFT = 12;
    localparam int PT_W      = PR_W - POS_SHIFT;
    localparam int VP_W      = SW + OPND_W;
    localparam int VT_W      = VP_W - VEL_SHIFT;
    localparam int NS_W      = ((PT_W > VT_W) ? PT_W : VT_W) + 2;
    localparam int SLP_W     = 2 * OPND_W;
    localparam int MS_W      = 13;
    localparam int SL_W      = NUDGE_W + 2;

    localparam logic [PR_W-1:0] LEAK_HALF = PR_W'(1) << (LEAK_SHIFT - 1);
    localparam logic [PR_W-1:0] POS_HALF  = PR_W'(1) << (POS_SHIFT - 1);
    localparam logic [VP_W-1:0] VEL_HALF  = VP_W'(1) << (VEL_SHIFT - 1);

    localparam logic [SUM_W-1:0] SAT_HI = {{(SUM_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic [SUM_W-1:0] SAT_LO = {{(SUM_W-IW+1){1'b1}}, {(IW-1){1'b0}}};

    // request kinds
    localparam logic OP_RESTART = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW     = 3'd4;

    // register reset values
    localparam logic [OPND_W-1:0]  POS_GAIN_RST = 16'd512;
    localparam logic [OPND_W-1:0]  VEL_GAIN_RST = 16'd256;
    localparam logic [OPND_W-1:0]  LEAK_RST     = 16'd65208;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 15'd1280;
    localparam logic [OPND_W-1:0]  SLEW_RST     = 16'd2560;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_DIV_INC,
        ST_ADD,
        ST_LEAK_GO,
        ST_MUL_LEAK,
        ST_POS_GO,
        ST_MUL_POS,
        ST_VEL_GO,
        ST_MUL_VEL,
        ST_SLEW_GO,
        ST_MUL_SLEW,
        ST_DIV_SLEW,
        ST_LIMIT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [OPND_W-1:0]  pos_gain_reg;
    logic [OPND_W-1:0]  vel_gain_reg;
    logic [OPND_W-1:0]  leak_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [OPND_W-1:0]  slew_reg;

    // request and working registers
    logic [SW-1:0]      smag_reg;
    logic               sneg_reg;
    logic [OPND_W-1:0]  step_reg;
    logic [INC_W:0]     inc_reg;
    logic [IW-1:0]      drift_reg;
    logic               dneg_reg;
    logic [IW-1:0]      lmag_reg;
    logic [PT_W-1:0]    pmag_reg;
    logic [VT_W-1:0]    vmag_reg;
    logic [PT_W:0]      pterm_reg;
    logic [VT_W:0]      vterm_reg;
    logic [NS_W-1:0]    sum_reg;
    logic [NUDGE_W-1:0] clamp_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [NUDGE_W-1:0] prev_reg;
    logic [NUDGE_W-1:0] res_nudge_reg;
    logic               res_held_reg;

    // shared unit requests
    logic               mul_start_reg;
    logic [IW-1:0]      mul_a_reg;
    logic [OPND_W-1:0]  mul_b_reg;
    logic               div_start_reg;
    logic [DIV_W-1:0]   div_num_reg;

    // output register
    logic               m_tvalid_reg;
    logic [NUDGE_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // unit results
    logic [PR_W-1:0]    mul_prod;
    unit_stat_t         mul_stat;
    logic [DIV_W-1:0]   div_quot;
    unit_stat_t         div_stat;

    // datapath values
    logic [SW-1:0]      speed_in;
    logic [OPND_W-1:0]  step_in;
    logic [SW-1:0]      speed_abs;
    logic [DIV_W-1:0]   inc_num;
    logic [INC_W:0]     inc_ext;
    logic [INC_W:0]     inc_next;
    logic [SUM_W-1:0]   add_sum;
    logic [IW-1:0]      drift_sat;
    logic [IW-1:0]      drift_abs;
    logic [PR_W-1:0]    leak_rnd;
    logic [PR_W-1:0]    pos_rnd;
    logic [VP_W-1:0]    vel_rnd;
    logic [PT_W:0]      pterm_next;
    logic [VT_W:0]      vterm_next;
    logic [NS_W-1:0]    nsum_next;
    logic [NS_W-1:0]    lim_ext;
    logic [NS_W-1:0]    nlim_ext;
    logic [NUDGE_W-1:0] clamp_next;
    logic [DIV_W-1:0]   slew_num;
    logic [SL_W-1:0]    prev_ext;
    logic [SL_W-1:0]    clamp_ext;
    logic [SL_W-1:0]    win_hi;
    logic [SL_W-1:0]    win_lo;
    logic [NUDGE_W-1:0] nudge_next;

    // shared serial units
    lpol_mul #(
        .MC_W    (IW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .mcand   (mul_a_reg),
        .mplier  (mul_b_reg),
        .prod    (mul_prod),
        .stat    (mul_stat)
    );

    lpol_div #(
        .NUM_W   (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    // request fields and speed magnitude
    assign speed_in  = s_tdata[SW-1:0];
    assign step_in   = s_tdata[SW+OPND_W-1:SW];
    assign speed_abs = speed_in[SW-1] ? (~speed_in + 1'b1) : speed_in;

    // integrator increment: speed*step*4096 rounded over one million
    assign inc_num  = {1'b0, mul_prod[P_W-1:0], {INC_SHIFT{1'b0}}}
                    + {{(DIV_W-DEN_W){1'b0}}, US_HALF};
    assign inc_ext  = {1'b0, div_quot[INC_W-1:0]};
    assign inc_next = sneg_reg ? (~inc_ext + 1'b1) : inc_ext;

    // saturating integrator add
    always_comb begin
        add_sum = {{(SUM_W-IW){drift_reg[IW-1]}}, drift_reg}
                + {{(SUM_W-INC_W-1){inc_reg[INC_W]}}, inc_reg};
        if ($signed(add_sum) > $signed(SAT_HI)) begin
            drift_sat = SAT_HI[IW-1:0];
        end else if ($signed(add_sum) < $signed(SAT_LO)) begin
            drift_sat = SAT_LO[IW-1:0];
        end else begin
            drift_sat = add_sum[IW-1:0];
        end
    end

    assign drift_abs = drift_reg[IW-1] ? (~drift_reg + 1'b1) : drift_reg;

    // rounded products, halves added before the shift
    assign leak_rnd = mul_prod + LEAK_HALF;
    assign pos_rnd  = mul_prod + POS_HALF;
    assign vel_rnd  = mul_prod[VP_W-1:0] + VEL_HALF;

    // both terms enter the nudge negated
    assign pterm_next = dneg_reg ? {1'b0, pmag_reg} : (~{1'b0, pmag_reg} + 1'b1);
    assign vterm_next = sneg_reg ? {1'b0, vmag_reg} : (~{1'b0, vmag_reg} + 1'b1);
    assign nsum_next  = {{(NS_W-PT_W-1){pterm_reg[PT_W]}}, pterm_reg}
                      + {{(NS_W-VT_W-1){vterm_reg[VT_W]}}, vterm_reg};

    // magnitude clamp
    assign lim_ext  = {{(NS_W-LIMIT_W){1'b0}}, limit_reg};
    assign nlim_ext = ~lim_ext + 1'b1;

    always_comb begin
        if ($signed(sum_reg) > $signed(lim_ext)) begin
            clamp_next = lim_ext[NUDGE_W-1:0];
        end else if ($signed(sum_reg) < $signed(nlim_ext)) begin
            clamp_next = nlim_ext[NUDGE_W-1:0];
        end else begin
            clamp_next = sum_reg[NUDGE_W-1:0];
        end
    end

    // slew allowance: slew_rate*step rounded over one million
    assign slew_num = {{(DIV_W-SLP_W){1'b0}}, mul_prod[SLP_W-1:0]}
                    + {{(DIV_W-DEN_W){1'b0}}, US_HALF};

    // slew window around the previous nudge
    assign prev_ext  = {{(SL_W-NUDGE_W){prev_reg[NUDGE_W-1]}}, prev_reg};
    assign clamp_ext = {{(SL_W-NUDGE_W){clamp_reg[NUDGE_W-1]}}, clamp_reg};
    assign win_hi    = prev_ext + {{(SL_W-MS_W){1'b0}}, ms_reg};
    assign win_lo    = prev_ext - {{(SL_W-MS_W){1'b0}}, ms_reg};

    always_comb begin
        if ($signed(clamp_ext) > $signed(win_hi)) begin
            nudge_next = win_hi[NUDGE_W-1:0];
        end else if ($signed(clamp_ext) < $signed(win_lo)) begin
            nudge_next = win_lo[NUDGE_W-1:0];
        end else begin
            nudge_next = clamp_reg;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_gain_reg <= POS_GAIN_RST;
            vel_gain_reg <= VEL_GAIN_RST;
            leak_reg     <= LEAK_RST;
            limit_reg    <= LIMIT_RST;
            slew_reg     <= SLEW_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_POS_GAIN: pos_gain_reg <= cfg_data;
                REG_VEL_GAIN: vel_gain_reg <= cfg_data;
                REG_LEAK: begin
                    if (cfg_data != '0) begin
                        leak_reg <= cfg_data;
                    end
                end
                REG_LIMIT:    limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_SLEW:     slew_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer, working registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            drift_reg     <= '0;
            prev_reg      <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        smag_reg <= speed_abs;
                        sneg_reg <= speed_in[SW-1];
                        step_reg <= step_in;
                        if (s_tuser[0] == OP_RESTART) begin
                            drift_reg     <= '0;
                            prev_reg      <= '0;
                            res_nudge_reg <= '0;
                            res_held_reg  <= 1'b0;
                            state_reg     <= ST_EMIT;
                        end else if (step_in == '0) begin
                            res_nudge_reg <= prev_reg;
                            res_held_reg  <= 1'b1;
                            state_reg     <= ST_EMIT;
                        end else begin
                            mul_a_reg     <= {{(IW-SW){1'b0}}, speed_abs};
                            mul_b_reg     <= step_in;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_MUL_P;
                        end
                    end
                end
                ST_MUL_P: begin
                    if (mul_stat.done) begin
                        div_num_reg   <= inc_num;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_INC;
                    end
                end
                ST_DIV_INC: begin
                    if (div_stat.done) begin
                        inc_reg   <= inc_next;
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    drift_reg <= drift_sat;
                    state_reg <= ST_LEAK_GO;
                end
                ST_LEAK_GO: begin
                    dneg_reg      <= drift_reg[IW-1];
                    mul_a_reg     <= drift_abs;
                    mul_b_reg     <= leak_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_LEAK;
                end
                ST_MUL_LEAK: begin
                    if (mul_stat.done) begin
                        lmag_reg  <= leak_rnd[PR_W-1:LEAK_SHIFT];
                        state_reg <= ST_POS_GO;
                    end
                end
                ST_POS_GO: begin
                    drift_reg     <= dneg_reg ? (~lmag_reg + 1'b1) : lmag_reg;
                    mul_a_reg     <= lmag_reg;
                    mul_b_reg     <= pos_gain_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_POS;
                end
                ST_MUL_POS: begin
                    if (mul_stat.done) begin
                        pmag_reg  <= pos_rnd[PR_W-1:POS_SHIFT];
                        state_reg <= ST_VEL_GO;
                    end
                end
                ST_VEL_GO: begin
                    pterm_reg     <= pterm_next;
                    mul_a_reg     <= {{(IW-SW){1'b0}}, smag_reg};
                    mul_b_reg     <= vel_gain_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_VEL;
                end
                ST_MUL_VEL: begin
                    if (mul_stat.done) begin
                        vmag_reg  <= vel_rnd[VP_W-1:VEL_SHIFT];
                        state_reg <= ST_SLEW_GO;
                    end
                end
                ST_SLEW_GO: begin
                    vterm_reg     <= vterm_next;
                    mul_a_reg     <= {{(IW-OPND_W){1'b0}}, slew_reg};
                    mul_b_reg     <= step_reg;
                    mul_start_reg <= 1'b1;
                    state_reg     <= ST_MUL_SLEW;
                end
                ST_MUL_SLEW: begin
                    // sum and clamp settle while the product runs
                    sum_reg   <= nsum_next;
                    clamp_reg <= clamp_next;
                    if (mul_stat.done) begin
                        div_num_reg   <= slew_num;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV_SLEW;
                    end
                end
                ST_DIV_SLEW: begin
                    if (div_stat.done) begin
                        ms_reg    <= div_quot[MS_W-1:0];
                        state_reg <= ST_LIMIT;
                    end
                end
                ST_LIMIT: begin
                    prev_reg      <= nudge_next;
                    res_nudge_reg <= nudge_next;
                    res_held_reg  <= 1'b0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_nudge_reg;
                        m_tuser_reg  <= res_held_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // a unit is never restarted while it is still running
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start_reg |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_stat.busy)
        else $error("divider started while busy");

    // the two serial units are used strictly one after the other
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_stat.busy && div_stat.busy))
        else $error("multiplier and divider running together");

    // a restart clears the integrator and the last nudge at once
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == OP_RESTART))
            |=> (drift_reg == '0) && (prev_reg == '0))
        else $error("restart left loop state behind");

endmodule

`default_nettype wire

>>> rtl/core/lpol_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module lpol_mul
    import lpol_pkg::*;
#(
    parameter int MC_W = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [MC_W-1:0]        mcand,
    input  wire logic [OPND_W-1:0]      mplier,
    output logic [MC_W+OPND_W-1:0]      prod,
    output unit_stat_t                  stat
);

    localparam int PR_W = MC_W + OPND_W;

    logic [PR_W-1:0]      prod_reg;
    logic [MC_W-1:0]      mcand_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MC_W:0]        part_next;

    // add the multiplicand into the upper half when the low bit is set
    always_comb begin
        part_next = {1'b0, prod_reg[PR_W-1:OPND_W]}
                  + (prod_reg[0] ? {1'b0, mcand_reg} : {(MC_W+1){1'b0}});
    end

    // upper half accumulates, multiplier bits shift out at the bottom
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mcand_reg <= mcand;
                prod_reg  <= {{MC_W{1'b0}}, mplier};
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                prod_reg <= {part_next, prod_reg[OPND_W-1:1]};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod      = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/lpol_div.sv
// bit-serial restoring divider by one million, one quotient bit per cycle
`default_nettype none

module lpol_div
    import lpol_pkg::*;
#(
    parameter int NUM_W = 44
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    output logic [NUM_W-1:0]      quot,
    output unit_stat_t            stat
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // trial subtraction of the divisor from the shifted remainder
    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, US_PER_S};
        fits  = (trial >= {1'b0, US_PER_S});
    end

    // numerator shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg  <= num;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> tb/sv/leaky_position_outer_loop_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the position outer loop: directed table, then random phases

module leaky_position_outer_loop_test;
    import lpol_pkg::*;

    localparam int SPEED_W  = 16;
    localparam int INTEG_W  = 32;
    localparam int S_DATA_W = ((SPEED_W + OPND_W + 7) / 8) * 8;

    // request kinds carried in tuser
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam int NUM_PHASES  = 14;
    localparam int PHASE_ITEMS = 95;
    localparam int SAT_ITEMS   = 300;
    localparam int PRESSURE_AT = 460;
    localparam int LONG_HOLD   = 1500;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        logic signed [NUDGE_W-1:0] nudge;
        logic                      held;
    } nudge_res_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [OPND_W-1:0]          data;
        logic                       op;
        logic signed [SPEED_W-1:0]  speed;
        logic [OPND_W-1:0]          step;
        bit                         typed;
        nudge_res_t                 want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [NUDGE_W-1:0]    m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [OPND_W-1:0]     cfg_data;

    // predictor state and register copies
    longint               drift_acc;
    longint               last_nudge;
    logic [OPND_W-1:0]    gain_pos;
    logic [OPND_W-1:0]    gain_vel;
    logic [OPND_W-1:0]    leak_q16;
    logic [LIMIT_W-1:0]   limit_mag;
    logic [OPND_W-1:0]    slew_per_s;

    nudge_res_t  nudge_q[$];
    dir_row_t    dir_tab[$];
    int          fail_count;
    int          results_seen;
    bit          pressure_done;
    bit          tx_idle;
    bit          rx_idle;

    leaky_position_outer_loop #(
        .INTEGRATOR_WIDTH(INTEG_W),
        .SPEED_WIDTH(SPEED_W)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // rounding to nearest, ties away from zero
    function automatic longint round_near(bit neg, longint unsigned mag, longint unsigned den);
        longint unsigned q;
        q = (mag + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // one request: restart, hold on zero step, or integrate, leak, pd, clamp, slew
    function automatic nudge_res_t outer_loop_step(logic op, logic signed [SPEED_W-1:0] speed,
                                                   logic [OPND_W-1:0] step);
        longint spd;
        longint inc;
        longint pterm;
        longint vterm;
        longint lean;
        longint lim;
        longint max_move;
        longint imax;
        longint imin;
        nudge_res_t res;
        spd = speed;
        imax = (longint'(1) <<< (INTEG_W - 1)) - 1;
        imin = -imax - 1;
        res = '0;
        if (op == OP_RESTART) begin
            drift_acc = 0;
            last_nudge = 0;
            return res;
        end
        if (step == '0) begin
            res.nudge = last_nudge[NUDGE_W-1:0];
            res.held = 1'b1;
            return res;
        end
        inc = round_near(spd < 0, abs64(spd) * 64'(step) * 64'd4096, 64'd1000000);
        drift_acc = drift_acc + inc;
        if (drift_acc > imax) drift_acc = imax;
        if (drift_acc < imin) drift_acc = imin;
        drift_acc = round_near(drift_acc < 0, abs64(drift_acc) * 64'(leak_q16), 64'd65536);
        pterm = round_near(drift_acc < 0, abs64(drift_acc) * 64'(gain_pos), 64'd1 << 24);
        vterm = round_near(spd < 0, abs64(spd) * 64'(gain_vel), 64'd4096);
        lean = -pterm - vterm;
        lim = longint'(limit_mag);
        if (lean > lim) lean = lim;
        if (lean < -lim) lean = -lim;
        max_move = round_near(1'b0, 64'(slew_per_s) * 64'(step), 64'd1000000);
        if (lean - last_nudge > max_move) begin
            lean = last_nudge + max_move;
        end else if (lean - last_nudge < -max_move) begin
            lean = last_nudge - max_move;
        end
        last_nudge = lean;
        res.nudge = lean[NUDGE_W-1:0];
        return res;
    endfunction

    // register write as the block sees it
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [OPND_W-1:0] data);
        case (idx)
            REG_POS_GAIN: gain_pos = data;
            REG_VEL_GAIN: gain_vel = data;
            REG_LEAK: begin
                // a zero leak is refused
                if (data != '0) leak_q16 = data;
            end
            REG_LIMIT: limit_mag = data[LIMIT_W-1:0];
            REG_SLEW: slew_per_s = data;
            default: ;
        endcase
    endfunction

    // table row builders
    function automatic dir_row_t req_row(logic op, logic signed [SPEED_W-1:0] speed,
                                         logic [OPND_W-1:0] step);
        dir_row_t r;
        r = '{kind: ROW_REQ, idx: '0, data: '0, op: op, speed: speed, step: step,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic dir_row_t typed_row(logic op, logic signed [SPEED_W-1:0] speed,
                                           logic [OPND_W-1:0] step,
                                           logic signed [NUDGE_W-1:0] nudge, logic held);
        dir_row_t r;
        r = req_row(op, speed, step);
        r.typed = 1'b1;
        r.want.nudge = nudge;
        r.want.held = held;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [OPND_W-1:0] data);
        dir_row_t r;
        r = req_row(OP_UPDATE, '0, '0);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // register value biased towards the ends of its range
    function automatic logic [OPND_W-1:0] pick_reg(logic [OPND_W-1:0] lo, logic [OPND_W-1:0] hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return OPND_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // offer one request, predict its result once accepted
    task automatic offer_req(input logic op, input logic signed [SPEED_W-1:0] speed,
                             input logic [OPND_W-1:0] step, input bit typed,
                             input nudge_res_t want);
        int gap;
        nudge_res_t got;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = S_DATA_W'({step, speed});
        s_tuser = op;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        got = outer_loop_step(op, speed, step);
        nudge_q.push_back(typed ? want : got);
    endtask

    // stop offering and wait until every result is back
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (nudge_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OPND_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // result side: random back-pressure, one long hold, field checks
    initial begin : result_side
        int gap;
        nudge_res_t want;
        wait (aresetn === 1'b1);
        forever begin
            gap = rx_idle ? $urandom_range(0, 5) : 0;
            if (results_seen == PRESSURE_AT && !pressure_done) begin
                gap = LONG_HOLD;
                pressure_done = 1'b1;
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                @(negedge aclk);
                m_tready = 1'b1;
            end else if (!m_tready) begin
                @(negedge aclk);
                m_tready = 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            results_seen++;
            if (nudge_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, got lean_nudge %0d held %0b",
                         $time, $signed(m_tdata), m_tuser[0]);
            end else begin
                want = nudge_q.pop_front();
                if (m_tdata !== want.nudge) begin
                    fail_count++;
                    $display("%0t: lean_nudge mismatch, expected %0d, got %0d",
                             $time, want.nudge, $signed(m_tdata));
                end
                if (m_tuser[0] !== want.held) begin
                    fail_count++;
                    $display("%0t: held mismatch, expected %0b, got %0b",
                             $time, want.held, m_tuser[0]);
                end
            end
        end
    end

    // stimulus
    initial begin : request_side
        int n;
        bit sat;
        bit run_neg;
        logic op;
        logic signed [SPEED_W-1:0] speed;
        logic [OPND_W-1:0] step;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        results_seen = 0;
        pressure_done = 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drift_acc = 0;
        last_nudge = 0;
        gain_pos = 16'd512;
        gain_vel = 16'd256;
        leak_q16 = 16'd65208;
        limit_mag = 15'd1280;
        slew_per_s = 16'd2560;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        dir_tab.push_back(typed_row(OP_UPDATE, 16'sd0, 16'd0, 16'sd0, 1'b1));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd32767, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, -16'sd32768, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd1234, 16'd0));
        dir_tab.push_back(typed_row(OP_RESTART, -16'sd32768, 16'hFFFF, 16'sd0, 1'b0));
        dir_tab.push_back(typed_row(OP_UPDATE, -16'sd32768, 16'd0, 16'sd0, 1'b1));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd0, 16'd1));
        dir_tab.push_back(req_row(OP_UPDATE, -16'sd1, 16'd1));
        dir_tab.push_back(cfg_row(REG_LIMIT, 16'd0));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd32767, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_POS_GAIN, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_VEL_GAIN, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_LEAK, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_LIMIT, 16'h7FFF));
        dir_tab.push_back(cfg_row(REG_SLEW, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, -16'sd32768, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd32767, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd32767, 16'hFFFF));
        // refused leak and writes past the register list
        dir_tab.push_back(cfg_row(REG_LEAK, 16'd0));
        dir_tab.push_back(cfg_row(REG_SPARE_FIRST, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_SPARE_LAST, 16'h0001));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd20000, 16'd40000));
        // zero slew rate freezes the nudge
        dir_tab.push_back(cfg_row(REG_SLEW, 16'd0));
        dir_tab.push_back(req_row(OP_UPDATE, -16'sd30000, 16'd5000));
        dir_tab.push_back(cfg_row(REG_LEAK, 16'd1));
        dir_tab.push_back(cfg_row(REG_POS_GAIN, 16'd0));
        dir_tab.push_back(cfg_row(REG_VEL_GAIN, 16'd0));
        dir_tab.push_back(cfg_row(REG_LIMIT, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, -16'sd32768, 16'hFFFF));
        dir_tab.push_back(cfg_row(REG_SLEW, 16'hFFFF));
        dir_tab.push_back(req_row(OP_UPDATE, 16'sd100, 16'd1));
        dir_tab.push_back(typed_row(OP_RESTART, 16'sd0, 16'd0, 16'sd0, 1'b0));

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                settle_idle();
                write_reg(dir_tab[k].idx, dir_tab[k].data);
            end else begin
                offer_req(dir_tab[k].op, dir_tab[k].speed, dir_tab[k].step,
                          dir_tab[k].typed, dir_tab[k].want);
            end
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            sat = (ph == 3 || ph == 9);
            run_neg = (ph == 9);
            if (ph == 0) begin
                write_reg(REG_POS_GAIN, 16'd512);
                write_reg(REG_VEL_GAIN, 16'd256);
                write_reg(REG_LEAK, 16'd65208);
                write_reg(REG_LIMIT, 16'd1280);
                write_reg(REG_SLEW, 16'd2560);
            end else begin
                write_reg(REG_POS_GAIN, pick_reg(16'd0, 16'hFFFF));
                write_reg(REG_VEL_GAIN, pick_reg(16'd0, 16'hFFFF));
                write_reg(REG_LEAK, sat ? 16'hFFFF : pick_reg(16'd0, 16'hFFFF));
                write_reg(REG_LIMIT, pick_reg(16'd0, 16'hFFFF));
                write_reg(REG_SLEW, pick_reg(16'd0, 16'hFFFF));
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                          16'($urandom));
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n = sat ? SAT_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n; i++) begin
                op = OP_UPDATE;
                if (sat) begin
                    // steady run one way to drive the integrator into saturation
                    speed = 16'($urandom_range(30000, 32767));
                    if (run_neg) speed = -16'($urandom_range(30000, 32768));
                    step = 16'($urandom_range(60000, 65535));
                end else begin
                    if ($urandom_range(0, 19) == 0) op = OP_RESTART;
                    if ($urandom_range(0, 1) == 0) begin
                        speed = 16'($urandom_range(0, 4000)) - 16'sd2000;
                    end else begin
                        speed = 16'($urandom);
                    end
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: step = 16'($urandom_range(500, 20000));
                        4, 5: step = 16'($urandom);
                        6: step = 16'hFFFF;
                        default: step = 16'($urandom_range(1, 10));
                    endcase
                end
                if ($urandom_range(0, 11) == 0) step = '0;
                offer_req(op, speed, step, 1'b0, '0);
            end
        end

        // drain and allow for stray results
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (nudge_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
